/* src/assert_macros.svh */
// assertion macros used by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* src/mpps_pkg.sv */
// types and constants of the multi-phase pwm sequencer
package mpps_pkg;

  localparam int TIME_W     = 32;
  localparam int PHASE_W    = 3;
  localparam int CYCLE_W    = 10;
  localparam int FRAC_W     = 16;
  localparam int FRAC_SHIFT = 15;
  localparam int NUM_W      = 26;
  localparam int LEVEL_W    = 8;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W     = NUM_W + TIME_W;

  // one whole period in q1.15
  localparam logic [FRAC_W-1:0] FRAC_ONE = 16'h8000;

  // wave mode codes; the spare code acts as full
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_TICKS,
    REG_WAVE_MODE,
    REG_PHASE_COUNT,
    REG_CHANNEL_COUNT,
    REG_FRACS_LOW,
    REG_FRACS_HIGH,
    REG_LEVEL_TABLE,
    REG_PAUSE_DELAY
  } cfg_reg_t;

  // operands of one toggle handed to the time stages
  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic               paused;
    logic [TIME_W-1:0]  base;
    logic [NUM_W-1:0]   num;
    logic [TIME_W-1:0]  period;
  } mpps_op_t;

  // sequencer state seen by the checks
  typedef struct packed {
    logic [PHASE_W-1:0] phase_pos;
    logic [CYCLE_W-1:0] cycle_count;
    logic               started;
  } mpps_status_t;

endpackage

/* src/mpps_phase_ctrl.sv */
// configuration registers, phase sequencing and operand register
module mpps_phase_ctrl #(
  parameter int MAX_PHASES   = 8,
  parameter int MAX_CHANNELS = 8,
  parameter int CYCLE_LIMIT  = 1000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mpps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mpps_pkg::TIME_W-1:0]         s_tdata,
  output logic                                op_valid,
  input  logic                                op_ready,
  output mpps_pkg::mpps_op_t                  op,
  output mpps_pkg::mpps_status_t              status
);
  import mpps_pkg::*;

  logic [TIME_W-1:0]     period_ticks;
  logic [MODE_W-1:0]     wave_mode;
  logic [COUNT_W-1:0]    phase_count;
  logic [COUNT_W-1:0]    channel_count;
  logic [CFG_DATA_W-1:0] switch_fracs_low;
  logic [CFG_DATA_W-1:0] switch_fracs_high;
  logic [CFG_DATA_W-1:0] level_table;
  logic [TIME_W-1:0]     pause_delay;

  logic [PHASE_W-1:0]    phase_pos;
  logic [CYCLE_W-1:0]    cycle_count;
  logic [TIME_W-1:0]     base_time;
  logic [TIME_W-1:0]     held_period;
  logic                  started;

  logic [PHASE_W-1:0]    phase_pos_next;
  logic [CYCLE_W-1:0]    cycle_count_next;
  logic [TIME_W-1:0]     base_time_next;
  logic [TIME_W-1:0]     held_period_next;

  logic                  accept;
  logic                  paused;
  logic                  normal;
  logic                  restart;
  logic                  cycle_end;
  logic [COUNT_W-1:0]    pc;
  logic [COUNT_W-1:0]    nch;
  logic [COUNT_W-1:0]    pos_inc;
  logic [PHASE_W-1:0]    pos_eff;
  logic [PHASE_W-1:0]    col;
  logic [CFG_DATA_W-1:0] frac_word;
  logic [FRAC_W-1:0]     frac;
  logic [CYCLE_W-1:0]    cc_eff;
  logic [LEVEL_W-1:0]    levels;
  logic [NUM_W-1:0]      num;
  mpps_op_t              op_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks      <= '0;
      wave_mode         <= MODE_NORMAL;
      phase_count       <= COUNT_W'(2);
      channel_count     <= COUNT_W'(1);
      switch_fracs_low  <= '0;
      switch_fracs_high <= '0;
      level_table       <= '0;
      pause_delay       <= TIME_W'(100000);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PERIOD_TICKS:  period_ticks      <= cfg_data[TIME_W-1:0];
        REG_WAVE_MODE:     wave_mode         <= cfg_data[MODE_W-1:0];
        REG_PHASE_COUNT:   phase_count       <= cfg_data[COUNT_W-1:0];
        REG_CHANNEL_COUNT: channel_count     <= cfg_data[COUNT_W-1:0];
        REG_FRACS_LOW:     switch_fracs_low  <= cfg_data;
        REG_FRACS_HIGH:    switch_fracs_high <= cfg_data;
        REG_LEVEL_TABLE:   level_table       <= cfg_data;
        REG_PAUSE_DELAY:   pause_delay       <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !op_valid || op_ready;
  assign accept   = s_tvalid && s_tready;

  // phase selection, cycle restart and operand set-up
  always_comb begin
    paused = (period_ticks == '0);
    normal = (wave_mode == MODE_NORMAL);

    if (phase_count == '0) begin
      pc = COUNT_W'(1);
    end else if (phase_count > COUNT_W'(MAX_PHASES)) begin
      pc = COUNT_W'(MAX_PHASES);
    end else begin
      pc = phase_count;
    end

    if (channel_count > COUNT_W'(MAX_CHANNELS)) begin
      nch = COUNT_W'(MAX_CHANNELS);
    end else begin
      nch = channel_count;
    end

    // position past the count restarts at phase zero
    if (!normal || ({1'b0, phase_pos} >= pc)) begin
      pos_eff = '0;
    end else begin
      pos_eff = phase_pos;
    end

    restart = (pos_eff == '0) &&
              (!started || (held_period != period_ticks) ||
               (cycle_count >= CYCLE_W'(CYCLE_LIMIT)));

    base_time_next   = restart ? s_tdata : base_time;
    cc_eff           = restart ? '0 : cycle_count;
    held_period_next = restart ? period_ticks : held_period;

    // driven column and switch fraction
    frac_word = pos_eff[PHASE_W-1] ? switch_fracs_high : switch_fracs_low;
    if (paused) begin
      col  = '0;
      frac = FRAC_ONE;
    end else if (normal) begin
      col  = (pos_eff == '0) ? PHASE_W'(pc - COUNT_W'(1)) : pos_eff - PHASE_W'(1);
      frac = frac_word[{pos_eff[1:0], 4'b0000} +: FRAC_W];
    end else begin
      col  = (wave_mode == MODE_ZERO) ? PHASE_W'(0) : PHASE_W'(1);
      frac = FRAC_ONE;
    end

    // per-channel level lookup
    for (int ch = 0; ch < LEVEL_W; ch++) begin
      levels[ch] = (COUNT_W'(ch) < nch) && level_table[{PHASE_W'(ch), col}];
    end

    num = {1'b0, cc_eff, {FRAC_SHIFT{1'b0}}} + {{(NUM_W - FRAC_W){1'b0}}, frac};

    // advance to the next phase, closing the cycle when done
    pos_inc   = {1'b0, pos_eff} + COUNT_W'(1);
    cycle_end = !normal || (pos_inc >= pc);
    if (cycle_end) begin
      phase_pos_next   = '0;
      cycle_count_next = cc_eff + CYCLE_W'(1);
    end else begin
      phase_pos_next   = pos_inc[PHASE_W-1:0];
      cycle_count_next = cc_eff;
    end

    op_next.levels = levels;
    op_next.paused = paused;
    op_next.base   = paused ? s_tdata + pause_delay : base_time_next;
    op_next.num    = paused ? '0 : num;
    op_next.period = held_period_next;
  end

  // sequencer state, left alone while paused
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_pos   <= '0;
      cycle_count <= '0;
      base_time   <= '0;
      held_period <= '0;
      started     <= 1'b0;
    end else if (accept && !paused) begin
      phase_pos   <= phase_pos_next;
      cycle_count <= cycle_count_next;
      base_time   <= base_time_next;
      held_period <= held_period_next;
      started     <= 1'b1;
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (s_tready) begin
      op_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_next;
    end
  end

  assign status.phase_pos   = phase_pos;
  assign status.cycle_count = cycle_count;
  assign status.started     = started;

endmodule

/* src/mpps_time_calc.sv */
// product stage and final add into the result register
module mpps_time_calc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              op_valid,
  output logic                              op_ready,
  input  mpps_pkg::mpps_op_t                op,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,
  output logic                              m_tuser
);
  import mpps_pkg::*;

  logic                  p_valid;
  logic [LEVEL_W-1:0]    p_levels;
  logic                  p_paused;
  logic [TIME_W-1:0]     p_base;
  logic [TIME_W-1:0]     p_prod;
  logic [PROD_W-1:0]     prod_full;
  logic                  out_free;
  logic                  p_ready;

  assign out_free = !m_tvalid || m_tready;
  assign p_ready  = !p_valid || out_free;
  assign op_ready = p_ready;

  // fraction times period, floor by dropping the q1.15 bits
  assign prod_full = {{TIME_W{1'b0}}, op.num} * {{NUM_W{1'b0}}, op.period};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && op_valid) begin
      p_levels <= op.levels;
      p_paused <= op.paused;
      p_base   <= op.base;
      p_prod   <= prod_full[FRAC_SHIFT +: TIME_W];
    end
  end

  // result register, the wrap at 32 bits is the natural overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p_valid) begin
      m_tdata <= {p_base + p_prod, p_levels};
      m_tuser <= p_paused;
    end
  end

endmodule

/* src/multi_phase_pwm_sequencer_core.sv */
// top level of the multi-phase pwm sequencer
//
// each beat on the s_ channel is one timer expiry carrying the current tick
// time. the core answers with exactly one beat on the m_ channel: the pin
// levels for the channels, the absolute tick time of the next toggle and a
// paused flag that is set while the period register is zero.
// configuration is written through cfg_we / cfg_index / cfg_data while the
// core is idle; a write lands at the clock edge with cfg_we high.
// an accepted input beat passes the operand, product and result registers
// to its result beat, and the core takes one beat every cycle unless the
// receiver stalls; the 26 x 32 bit product has a stage of its own.
// the phase state is updated at the edge that accepts a beat, so the next
// beat may follow straight away.
// when the receiver stalls, the result register holds and the stages behind
// it keep filling; s_tready falls only once all three stages are full.
// rst (synchronous) empties the pipeline, restores the register defaults and
// clears the phase state so that the first timed beat restarts the cycle.
module multi_phase_pwm_sequencer_core #(
  parameter int MAX_PHASES   = 8,
  parameter int MAX_CHANNELS = 8,
  parameter int CYCLE_LIMIT  = 1000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mpps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // now_time[31:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,   // pin_levels[7:0], next_time[39:8]
  output logic                             m_tuser    // paused
);
  import mpps_pkg::*;

  logic         op_valid;
  logic         op_ready;
  mpps_op_t     op;
  mpps_status_t status;

  // configuration and phase sequencing
  mpps_phase_ctrl #(
    .MAX_PHASES   (MAX_PHASES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .CYCLE_LIMIT  (CYCLE_LIMIT)
  ) u_phase_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .status    (status)
  );

  // toggle time arithmetic and result register
  mpps_time_calc u_time_calc (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // checks on the sequencer state and result
  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cycle_bound, status.cycle_count <= CYCLE_W'(CYCLE_LIMIT), "cycle count past limit")
  `ASSERT_ALWAYS(a_phase_bound, {1'b0, status.phase_pos} < COUNT_W'(MAX_PHASES), "phase beyond table")
  `ASSERT_IMPLIES(a_fresh_state, !status.started, (status.cycle_count == '0) && (status.phase_pos == '0), "state moved before first timed beat")
  `ASSERT_IMPLIES(a_unused_pins, m_tvalid, (m_tdata[7:0] >> MAX_CHANNELS) == 8'd0, "unused channel driven")

endmodule

/* test/multi_phase_pwm_sequencer_core_test.sv */
// self-checking testbench of the multi-phase pwm sequencer core
module multi_phase_pwm_sequencer_core_test;
  import mpps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES_MAX    = 8;
  localparam int CHANNELS_MAX  = 8;
  localparam int CYCLE_CAP     = 1000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_TICKS  = 480;

  // mode codes the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_FULL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // one result beat as the core should return it
  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic [TIME_W-1:0]  next;
    logic               paused;
  } tick_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = REG_PERIOD_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;    // now_time[31:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;         // pin_levels[7:0], next_time[39:8]
  logic                  m_tuser;         // paused

  // shadow of the configuration registers
  logic [TIME_W-1:0]     period_q    = '0;
  logic [MODE_W-1:0]     mode_q      = MODE_NORMAL;
  logic [COUNT_W-1:0]    phase_cnt_q = 4'd2;
  logic [COUNT_W-1:0]    chan_cnt_q  = 4'd1;
  logic [63:0]           fracs_lo_q  = '0;
  logic [63:0]           fracs_hi_q  = '0;
  logic [63:0]           lvl_table_q = '0;
  logic [TIME_W-1:0]     pause_q     = 32'd100000;

  // sequencer state as predicted
  logic [PHASE_W-1:0]    phase_pos   = '0;
  logic [CYCLE_W-1:0]    cycle_cnt   = '0;
  logic [TIME_W-1:0]     base_time   = '0;
  logic [TIME_W-1:0]     held_period = '0;
  logic                  started     = 1'b0;

  tick_result_t          expected_ticks[$];
  int                    mismatches = 0;
  logic                  quiet = 1'b0;
  int                    hold_asks = 0;
  int                    hold_seen = 0;
  int                    hold_left = 0;
  int                    stall_cycles = 0;
  logic [TIME_W-1:0]     tick_now = '0;

  multi_phase_pwm_sequencer_core #(
    .MAX_PHASES  (PHASES_MAX),
    .MAX_CHANNELS(CHANNELS_MAX),
    .CYCLE_LIMIT (CYCLE_CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // pin levels of one table column over the driven channels
  function automatic logic [LEVEL_W-1:0] column_levels(logic [2:0] col);
    logic [LEVEL_W-1:0] lv;
    int nch;
    lv = '0;
    nch = (chan_cnt_q > CHANNELS_MAX) ? CHANNELS_MAX : int'(chan_cnt_q);
    for (int ch = 0; ch < nch; ch++) lv[ch] = lvl_table_q[ch * 8 + col];
    return lv;
  endfunction

  // next toggle and pin levels for one timer expiry; advances the phase state
  function automatic tick_result_t predict_tick(logic [TIME_W-1:0] now);
    tick_result_t r;
    logic [COUNT_W-1:0] pc;
    logic [PHASE_W-1:0] nxt_pos;
    logic [2:0]         col;
    logic [FRAC_W-1:0]  frac;
    logic [63:0]        num;
    logic               normal;
    normal = (mode_q == MODE_NORMAL);
    // parked while the period is zero, state untouched
    if (period_q == '0) begin
      r.levels = column_levels(3'd0);
      r.next   = now + pause_q;
      r.paused = 1'b1;
      return r;
    end
    pc = (phase_cnt_q == 0) ? 4'd1 : phase_cnt_q;
    if (pc > PHASES_MAX) pc = COUNT_W'(PHASES_MAX);
    if (!normal || phase_pos >= pc) phase_pos = '0;
    // new cycle restarts the base time when needed
    if (phase_pos == '0 &&
        (!started || held_period != period_q || cycle_cnt >= CYCLE_CAP)) begin
      base_time   = now;
      cycle_cnt   = '0;
      held_period = period_q;
      started     = 1'b1;
    end
    if (normal) begin
      col  = (phase_pos == '0) ? 3'(pc - 4'd1) : 3'(phase_pos - 3'd1);
      frac = (phase_pos < 4) ? fracs_lo_q[16 * phase_pos[1:0] +: 16]
                             : fracs_hi_q[16 * phase_pos[1:0] +: 16];
    end else begin
      col  = (mode_q == MODE_ZERO) ? 3'd0 : 3'd1;
      frac = FRAC_ONE;
    end
    num = (64'(cycle_cnt) << FRAC_SHIFT) + 64'(frac);
    num = (num * 64'(held_period)) >> FRAC_SHIFT;
    r.levels = column_levels(col);
    r.next   = base_time + num[31:0];
    r.paused = 1'b0;
    // step the phase, closing the cycle on wrap
    nxt_pos = phase_pos + 3'd1;
    if (!normal || nxt_pos >= pc || nxt_pos == '0) begin
      phase_pos = '0;
      cycle_cnt = cycle_cnt + 10'd1;
    end else begin
      phase_pos = nxt_pos;
    end
    return r;
  endfunction

  // offer one expiry beat and log its expected result on acceptance
  task automatic send_tick(input logic [TIME_W-1:0] now);
    int gap;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < 20) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= now;
    do @(posedge clk); while (!s_tready);
    expected_ticks.push_back(predict_tick(now));
  endtask

  // tick time moving forward, now and then jumping anywhere
  task automatic advance_now();
    if ($urandom_range(7) == 0) tick_now = $urandom;
    else tick_now = tick_now + $urandom_range(2000);
  endtask

  // wait until every result is back and the core has gone quiet
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write, mirrored into the shadow
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PERIOD_TICKS:  period_q    = val[31:0];
      REG_WAVE_MODE:     mode_q      = val[1:0];
      REG_PHASE_COUNT:   phase_cnt_q = val[3:0];
      REG_CHANNEL_COUNT: chan_cnt_q  = val[3:0];
      REG_FRACS_LOW:     fracs_lo_q  = val;
      REG_FRACS_HIGH:    fracs_hi_q  = val;
      REG_LEVEL_TABLE:   lvl_table_q = val;
      REG_PAUSE_DELAY:   pause_q     = val[31:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // parked output with reset defaults, then with a full table and max and zero delay
  task automatic test_paused_output();
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, 64'd8);
    write_reg(REG_LEVEL_TABLE, {$urandom, $urandom});
    write_reg(REG_PAUSE_DELAY, 64'hFFFF_FFFF);
    send_tick(32'h8000_0001);
    wait_drained();
    write_reg(REG_PAUSE_DELAY, 64'd0);
    send_tick(32'h7FFF_FFFE);
    wait_drained();
  endtask

  // three-phase cycle, then a period change part way through a cycle
  task automatic test_phase_sequence();
    write_reg(REG_PHASE_COUNT, 64'd3);
    write_reg(REG_FRACS_LOW, {16'h8000, 16'h6000, 16'h2000, 16'h0000});
    write_reg(REG_FRACS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PERIOD_TICKS, 64'd1000);
    for (int i = 0; i < 5; i++) send_tick(32'd5000 + 32'(i * 300));
    wait_drained();
    write_reg(REG_PERIOD_TICKS, 64'd999);
    for (int i = 0; i < 3; i++) send_tick(32'd9000 + 32'(i * 300));
    wait_drained();
  endtask

  // zero, full and the spare mode code
  task automatic test_fixed_modes();
    write_reg(REG_WAVE_MODE, 64'(MODE_ZERO));
    send_tick(32'd20000);
    wait_drained();
    write_reg(REG_WAVE_MODE, 64'(MODE_FULL));
    send_tick(32'd21000);
    wait_drained();
    write_reg(REG_WAVE_MODE, 64'(MODE_SPARE));
    send_tick(32'd22000);
    wait_drained();
    write_reg(REG_WAVE_MODE, 64'(MODE_NORMAL));
  endtask

  // counts outside their range, widest period and fraction, shrinking phase count
  task automatic test_count_limits();
    write_reg(REG_PHASE_COUNT, 64'd0);
    write_reg(REG_CHANNEL_COUNT, 64'd15);
    write_reg(REG_FRACS_LOW, 64'h0000_0000_0000_FFFF);
    write_reg(REG_PERIOD_TICKS, 64'hFFFF_FFFF);
    send_tick(32'hFFFF_FF00);
    send_tick(32'hFFFF_FFF0);
    wait_drained();
    write_reg(REG_PHASE_COUNT, 64'd15);
    write_reg(REG_CHANNEL_COUNT, 64'd0);
    write_reg(REG_FRACS_LOW, {$urandom, $urandom});
    write_reg(REG_PERIOD_TICKS, 64'd1);
    for (int i = 0; i < 3; i++) send_tick(32'd100 + 32'(i));
    wait_drained();
    // position now beyond the lowered count
    write_reg(REG_PHASE_COUNT, 64'd2);
    write_reg(REG_CHANNEL_COUNT, 64'd5);
    send_tick(32'd200);
    send_tick(32'd201);
    wait_drained();
  endtask

  // receiver holds off while beats keep coming, so the input stalls
  task automatic test_input_stall();
    write_reg(REG_PHASE_COUNT, 64'd4);
    write_reg(REG_PERIOD_TICKS, 64'd500);
    quiet <= 1'b1;
    hold_asks <= hold_asks + 1;
    for (int i = 0; i < 30; i++) begin
      advance_now();
      send_tick(tick_now);
    end
    wait_drained();
    quiet <= 1'b0;
  endtask

  // random settings per phase, random expiry times within each
  task automatic test_random_phases();
    int sent;
    int n;
    logic [31:0] per;
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(7))
          0:       per = '0;
          1:       per = 32'd1;
          2:       per = 32'hFFFF_FFFF;
          3, 4:    per = $urandom_range(64, 1);
          default: per = $urandom;
        endcase
        write_reg(REG_PERIOD_TICKS, 64'(per));
      end
      if ($urandom_range(1) == 1)
        write_reg(REG_WAVE_MODE, ($urandom_range(2) != 0) ? 64'(MODE_NORMAL)
                                                          : 64'($urandom_range(3)));
      if ($urandom_range(1) == 1)
        write_reg(REG_PHASE_COUNT, ($urandom_range(3) == 0) ? 64'($urandom_range(15))
                                                            : 64'($urandom_range(8, 1)));
      if ($urandom_range(1) == 1)
        write_reg(REG_CHANNEL_COUNT, ($urandom_range(3) == 0) ? 64'($urandom_range(15))
                                                              : 64'($urandom_range(8, 1)));
      if ($urandom_range(2) == 0) write_reg(REG_FRACS_LOW, {$urandom, $urandom});
      if ($urandom_range(2) == 0) write_reg(REG_FRACS_HIGH, {$urandom, $urandom});
      if ($urandom_range(1) == 1) write_reg(REG_LEVEL_TABLE, {$urandom, $urandom});
      if ($urandom_range(3) == 0) write_reg(REG_PAUSE_DELAY, 64'($urandom));
      // some phases run without any idling
      quiet <= ($urandom_range(4) == 0);
      n = $urandom_range(50, 15);
      for (int i = 0; i < n; i++) begin
        advance_now();
        send_tick(tick_now);
      end
      sent += n;
      wait_drained();
    end
    quiet <= 1'b0;
  endtask

  // receiver: check each result beat and drive m_tready
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_ticks.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat %h paused %b", m_tdata, m_tuser);
      end else begin
        want = expected_ticks.pop_front();
        if (m_tdata[7:0] !== want.levels || m_tdata[39:8] !== want.next ||
            m_tuser !== want.paused) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display({"result mismatch: levels exp %h got %h, next exp %h got %h, ",
                      "paused exp %b got %b"},
                     want.levels, m_tdata[7:0], want.next, m_tdata[39:8],
                     want.paused, m_tuser);
        end
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
    end
  end

  // watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_paused_output();
    test_phase_sequence();
    test_fixed_modes();
    test_count_limits();
    test_input_stall();
    test_random_phases();
    wait_drained();
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
